@@ sv/sli_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted list package
// Shared types and constants for the sorted insert/remove block.
// ----------------------------------------------------------------------------
package sli_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int COUNT_OUT_W  = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic capture;  // latch the transaction and the compare flags
        logic apply;    // shift the entries and load the result register
    } t_cmd;

endpackage

@@ sv/sli_in_if.sv @@
// ----------------------------------------------------------------------------
// Operation channel
// Valid/ready channel carrying one insert or remove operation.
// ----------------------------------------------------------------------------
interface sli_in_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [sli_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

@@ sv/sli_out_if.sv @@
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the status, entry count and smallest entry.
// ----------------------------------------------------------------------------
interface sli_out_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        status;
    logic [sli_pkg::COUNT_OUT_W-1:0]   entry_count;
    logic [sli_pkg::VALUE_W-1:0]       smallest;

    modport source (output valid, output status, output entry_count, output smallest,
                    input ready);
    modport sink   (input valid, input status, input entry_count, input smallest,
                    output ready);
endinterface

@@ sv/sorted_list_insert_remove.sv @@
// ----------------------------------------------------------------------------
// Sorted list insert/remove
// Bounded ascending multiset of signed 32-bit values with insert and remove.
// ----------------------------------------------------------------------------
// A transaction runs as a capture step and then an update step: in the capture
// step the value is compared against every stored entry at once and the
// per-entry flags are registered; in the update step the entry row shifts (up
// for an insert, down for a remove) and the result register is loaded. A new
// transaction is taken in the cycle after the update, not before the current
// one is applied, and a stalled result holds the update step. Inserts
// go after equal entries, an insert into a full list reports full, and a
// remove with no match reports not found. entry_count carries the low five
// bits of the count; smallest reads zero when the list is empty.
module sorted_list_insert_remove #(
    parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sli_in_if.sink     i_in,
    sli_out_if.source  o_out
);

    sli_pkg::t_cmd cmd;

    sli_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    sli_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_opcode      (i_in.opcode),
        .i_value       (i_in.value),
        .o_status      (o_out.status),
        .o_entry_count (o_out.entry_count),
        .o_smallest    (o_out.smallest)
    );

endmodule

@@ sv/sli_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sorted list controller
// Two-state sequencer: take a transaction, then apply it once the result
// register is free.
// ----------------------------------------------------------------------------
module sli_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sli_pkg::t_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_UPDATE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
        o_cmd.apply   = (r_state == S_UPDATE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_out_ready) r_out_valid <= 1'b0;
                    if (i_in_valid)  r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    // hold until the previous result has been taken
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

endmodule

@@ sv/sli_datapath.sv @@
// ----------------------------------------------------------------------------
// Sorted list datapath
// Row of entry cells with per-cell compare flags, shift logic, entry count
// and the result register.
// ----------------------------------------------------------------------------
module sli_datapath #(
    parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sli_pkg::t_cmd                     i_cmd,
    input  logic                              i_opcode,
    input  logic [sli_pkg::VALUE_W-1:0]       i_value,
    output logic [1:0]                        o_status,
    output logic [sli_pkg::COUNT_OUT_W-1:0]   o_entry_count,
    output logic [sli_pkg::VALUE_W-1:0]       o_smallest
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int VW = sli_pkg::VALUE_W;

    logic [VW-1:0]       r_entry [CAPACITY];
    logic [VW-1:0]       n_entry [CAPACITY];
    logic [CAPACITY-1:0] r_lt;   // value sorts before the cell (empty cells count as above)
    logic [CAPACITY-1:0] r_le;   // value at or below a valid cell
    logic [CAPACITY-1:0] r_eq;   // valid cell equals value
    logic [CAPACITY-1:0] cell_valid;
    logic                r_op;
    logic [VW-1:0]       r_val;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    sli_pkg::t_status    n_status;
    logic                full;
    logic                found;
    logic                do_ins;
    logic                do_rem;
    logic [31:0]         count_ext;

    logic [1:0]                       r_status;
    logic [sli_pkg::COUNT_OUT_W-1:0]  r_entry_count;
    logic [VW-1:0]                    r_smallest;

    assign full   = (r_count >= CW'(CAPACITY));
    assign found  = |r_eq;
    assign do_ins = (r_op == sli_pkg::OP_INSERT) && !full;
    assign do_rem = (r_op == sli_pkg::OP_REMOVE) && found;

    always_comb begin
        n_count  = r_count;
        n_status = sli_pkg::ST_DONE;
        if (r_op == sli_pkg::OP_INSERT) begin
            if (full) n_status = sli_pkg::ST_FULL;
            else      n_count  = r_count + CW'(1);
        end else begin
            if (found) n_count  = r_count - CW'(1);
            else       n_status = sli_pkg::ST_NOT_FOUND;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic prev_lt;
            logic [VW-1:0] prev_e;
            logic [VW-1:0] next_e;

            assign cell_valid[gi] = (CW'(gi) < r_count);

            if (gi == 0) begin : g_first
                assign prev_lt = 1'b0;
                assign prev_e  = r_entry[gi];
            end else begin : g_mid
                assign prev_lt = r_lt[gi-1];
                assign prev_e  = r_entry[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign next_e = r_entry[gi];
            end else begin : g_inner
                assign next_e = r_entry[gi+1];
            end

            always_comb begin
                n_entry[gi] = r_entry[gi];
                // open a slot: the first cell above the value takes it, later ones shift up
                if (do_ins && r_lt[gi] && (CW'(gi) <= r_count)) begin
                    n_entry[gi] = prev_lt ? prev_e : r_val;
                end
                // close the gap from the first match upward
                if (do_rem && r_le[gi]) begin
                    n_entry[gi] = next_e;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_cmd.capture) begin
                    r_lt[gi] <= !cell_valid[gi] || ($signed(i_value) < $signed(r_entry[gi]));
                    r_le[gi] <= cell_valid[gi] && ($signed(i_value) <= $signed(r_entry[gi]));
                    r_eq[gi] <= cell_valid[gi] && (i_value == r_entry[gi]);
                end
                if (i_cmd.apply) begin
                    r_entry[gi] <= n_entry[gi];
                end
            end
        end
    endgenerate

    assign count_ext = 32'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.apply) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_opcode;
            r_val <= i_value;
        end
        if (i_cmd.apply) begin
            r_status      <= n_status;
            r_entry_count <= count_ext[sli_pkg::COUNT_OUT_W-1:0];
            r_smallest    <= (n_count != '0) ? n_entry[0] : '0;
        end
    end

    assign o_status      = r_status;
    assign o_entry_count = r_entry_count;
    assign o_smallest    = r_smallest;

endmodule
